FILE: hdl/assert_macros.svh
// Assertion macros for the cell pair gap checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is applied
`define CPGD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same-cycle implication
`define CPGD_ASSERT_IMPLY(label, pre, post, msg) \
	`CPGD_ASSERT(label, (pre) |-> (post), msg)

`endif

FILE: hdl/cpgd_pkg.sv
// Shared constants, types and register codes of the cell pair gap filter
package cpgd_pkg;

	localparam int INDEX_BITS = 16;
	localparam int FRAC_BITS  = 8;

	localparam int FIELD_W      = 16;
	localparam int GAP_W        = INDEX_BITS;
	localparam int SQ_W         = 2 * INDEX_BITS;
	localparam int SUM_W        = 2 * INDEX_BITS + 2;
	localparam int ROOT_W       = INDEX_BITS + 1 + FRAC_BITS;
	localparam int RAD_W        = 2 * ROOT_W;
	localparam int GAP_CELLS_W  = 25;
	localparam int GAP_LENGTH_W = 33;
	localparam int CELL_LEN_W   = 16;
	localparam int CUTOFF_W     = 24;
	localparam int CUTOFF_SQ_W  = 2 * CUTOFF_W;
	localparam int CUT_SHIFT    = 16;
	localparam int CMP_W        = (SUM_W + CUT_SHIFT > CUTOFF_SQ_W) ?
		(SUM_W + CUT_SHIFT) : CUTOFF_SQ_W;
	localparam int ROOTX_W      = (ROOT_W > GAP_CELLS_W) ? ROOT_W : GAP_CELLS_W;
	localparam int PROD_W       = GAP_CELLS_W + CELL_LEN_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;

	localparam logic [CELL_LEN_W-1:0] DEFAULT_CELL_LENGTH = CELL_LEN_W'(10 << 8);
	localparam logic [GAP_CELLS_W-1:0] GAP_CELLS_MAX = {GAP_CELLS_W{1'b1}};
	localparam logic [GAP_LENGTH_W-1:0] GAP_LENGTH_MAX = {GAP_LENGTH_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_LENGTH   = 2'd0,
		REG_CUTOFF_CELLS  = 2'd1,
		REG_CUTOFF_ENABLE = 2'd2
	} cfg_reg_t;

	// Sum of squared gaps with its cutoff flag
	typedef struct packed {
		logic             in_range;
		logic [SUM_W-1:0] sum;
	} sum_word_t;

	// Square root with its cutoff flag
	typedef struct packed {
		logic              in_range;
		logic [ROOT_W-1:0] root;
	} root_word_t;

endpackage

FILE: hdl/cpgd_front.sv
// Axis gaps, squares, sum and cutoff test: four pipeline stages
module cpgd_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cpgd_pkg::FIELD_W-1:0]        first_i,
	input  logic [cpgd_pkg::FIELD_W-1:0]        first_j,
	input  logic [cpgd_pkg::FIELD_W-1:0]        first_k,
	input  logic [cpgd_pkg::FIELD_W-1:0]        second_i,
	input  logic [cpgd_pkg::FIELD_W-1:0]        second_j,
	input  logic [cpgd_pkg::FIELD_W-1:0]        second_k,
	input  logic                                cutoff_enable,
	input  logic [cpgd_pkg::CUTOFF_SQ_W-1:0]    cutoff_sq,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cpgd_pkg::sum_word_t                 out_word
);

	localparam int IB    = cpgd_pkg::INDEX_BITS;
	localparam int GW    = cpgd_pkg::GAP_W;
	localparam int SQW   = cpgd_pkg::SQ_W;
	localparam int SW    = cpgd_pkg::SUM_W;
	localparam int CW    = cpgd_pkg::CMP_W;

	function automatic logic [GW-1:0] axis_gap(
		input logic [cpgd_pkg::FIELD_W-1:0] a_raw,
		input logic [cpgd_pkg::FIELD_W-1:0] b_raw
	);
		logic [IB:0] a;
		logic [IB:0] b;
		logic [IB:0] d;
		logic [IB:0] mag;
		a   = {a_raw[IB-1], a_raw[IB-1:0]};
		b   = {b_raw[IB-1], b_raw[IB-1:0]};
		d   = a - b;
		mag = d[IB] ? (~d + (IB+1)'(1)) : d;
		// equal cells touch: gap is zero, otherwise one cell fewer
		return (mag == '0) ? '0 : GW'(mag - (IB+1)'(1));
	endfunction

	logic           v_s1, v_s2, v_s3, v_s4;
	logic           adv_s1, adv_s2, adv_s3, adv_s4;
	logic [GW-1:0]  gap_x_s1, gap_y_s1, gap_z_s1;
	logic [SQW-1:0] sq_x_s2, sq_y_s2, sq_z_s2;
	logic [SW-1:0]  sum_s3;
	cpgd_pkg::sum_word_t word_s4;
	logic [CW-1:0]  lhs;
	logic           in_range;

	// a stage advances when it is empty or the next one advances
	assign adv_s4   = !v_s4 || out_ready;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign lhs      = CW'(sum_s3) << cpgd_pkg::CUT_SHIFT;
	assign in_range = !cutoff_enable || (lhs < CW'(cutoff_sq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			gap_x_s1 <= axis_gap(first_i, second_i);
			gap_y_s1 <= axis_gap(first_j, second_j);
			gap_z_s1 <= axis_gap(first_k, second_k);
		end
		if (adv_s2) begin
			sq_x_s2 <= SQW'(gap_x_s1 * gap_x_s1);
			sq_y_s2 <= SQW'(gap_y_s1 * gap_y_s1);
			sq_z_s2 <= SQW'(gap_z_s1 * gap_z_s1);
		end
		if (adv_s3) begin
			sum_s3 <= SW'(sq_x_s2) + SW'(sq_y_s2) + SW'(sq_z_s2);
		end
		if (adv_s4) begin
			word_s4.sum      <= sum_s3;
			word_s4.in_range <= in_range;
		end
	end

	assign out_valid = v_s4;
	assign out_word  = word_s4;

endmodule

FILE: hdl/cpgd_sqrt.sv
// Fixed-point square root, one result bit per pipeline stage
module cpgd_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cpgd_pkg::sum_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cpgd_pkg::root_word_t out_word
);

	localparam int RW = cpgd_pkg::ROOT_W;
	localparam int DW = cpgd_pkg::RAD_W;

	logic          v_s      [RW];
	logic          adv      [RW];
	logic          within_s [RW];
	logic [RW-1:0] root_s   [RW];
	logic [DW-1:0] rem_s    [RW-1];

	for (genvar g = 0; g < RW; g++) begin : g_bit
		localparam int B = RW - 1 - g;

		logic [DW-1:0] rem_in;
		logic [DW-1:0] term;
		logic [RW-1:0] root_in;
		logic          within_in;
		logic          v_in;
		logic          adv_next;
		logic          take;

		if (g == 0) begin : g_head
			assign rem_in    = DW'(in_word.sum) << (2 * cpgd_pkg::FRAC_BITS);
			assign root_in   = '0;
			assign within_in = in_word.in_range;
			assign v_in      = in_valid;
		end else begin : g_body
			assign rem_in    = rem_s[g-1];
			assign root_in   = root_s[g-1];
			assign within_in = within_s[g-1];
			assign v_in      = v_s[g-1];
		end

		if (g == RW - 1) begin : g_last
			assign adv_next = out_ready;
		end else begin : g_mid
			assign adv_next = adv[g+1];
		end

		assign adv[g] = !v_s[g] || adv_next;

		// (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
		assign term = (DW'(root_in) << (B + 1)) | (DW'(1) << (2 * B));
		assign take = rem_in >= term;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (adv[g]) begin
				v_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[g]) begin
				within_s[g] <= within_in;
				root_s[g]   <= take ? (root_in | (RW'(1) << B)) : root_in;
			end
		end

		if (g < RW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv[g]) begin
					rem_s[g] <= take ? (rem_in - term) : rem_in;
				end
			end
		end
	end

	assign in_ready          = adv[0];
	assign out_valid         = v_s[RW-1];
	assign out_word.in_range = within_s[RW-1];
	assign out_word.root     = root_s[RW-1];

endmodule

FILE: hdl/cpgd_back.sv
// Saturate the root, scale by cell length, register the result word
module cpgd_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  cpgd_pkg::root_word_t                 in_word,
	input  logic [cpgd_pkg::CELL_LEN_W-1:0]      cell_length,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 within_res,
	output logic [cpgd_pkg::GAP_CELLS_W-1:0]     gap_cells,
	output logic [cpgd_pkg::GAP_LENGTH_W-1:0]    gap_length
);

	localparam int XW = cpgd_pkg::ROOTX_W;
	localparam int GW = cpgd_pkg::GAP_CELLS_W;
	localparam int LW = cpgd_pkg::GAP_LENGTH_W;
	localparam int PW = cpgd_pkg::PROD_W;

	logic          v_s1, v_s2;
	logic          adv_s1, adv_s2;
	logic [XW-1:0] root_x;
	logic [GW-1:0] gap_sat;
	logic [GW-1:0] gap_s1, gap_s2;
	logic [PW-1:0] prod_s1;
	logic [PW-1:0] len_x;
	logic [LW-1:0] len_sat;
	logic          within_s1, within_s2;
	logic [LW-1:0] len_s2;

	assign adv_s2   = !v_s2 || out_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign root_x  = XW'(in_word.root);
	assign gap_sat = (root_x > XW'(cpgd_pkg::GAP_CELLS_MAX)) ?
		cpgd_pkg::GAP_CELLS_MAX : root_x[GW-1:0];

	assign len_x   = prod_s1 >> cpgd_pkg::FRAC_BITS;
	assign len_sat = (len_x > PW'(cpgd_pkg::GAP_LENGTH_MAX)) ?
		cpgd_pkg::GAP_LENGTH_MAX : len_x[LW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			gap_s1    <= gap_sat;
			within_s1 <= in_word.in_range;
			prod_s1   <= PW'(gap_sat) * PW'(cell_length);
		end
		if (adv_s2) begin
			gap_s2    <= gap_s1;
			within_s2 <= within_s1;
			len_s2    <= len_sat;
		end
	end

	assign out_valid  = v_s2;
	assign within_res = within_s2;
	assign gap_cells  = gap_s2;
	assign gap_length = len_s2;

endmodule

FILE: hdl/cell_pair_gap_distance_filter.sv
// Top level: configuration registers and the three pipeline sections
//
//  channel  | handshake           | word
//  ---------+---------------------+----------------------------------------------
//  in       | in_valid/in_ready   | first_i/j/k, second_i/j/k
//  out      | out_valid/out_ready | within_res, gap_cells, gap_length
//  cfg      | cfg_we              | cfg_index, cfg_data
//
// One word enters per cycle while in_ready is high; it passes 4 front stages (gaps, squares,
// sum, cutoff compare), 25 square-root stages of one result bit each, 2 scaling stages.
// Each stage advances when it is empty or its successor advances, so bubbles close
// up and in_ready stays high while any stage is free, even with out_ready low.
// Reset clears the valid bits and loads the register defaults; nothing else to sweep.
module cell_pair_gap_distance_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [cpgd_pkg::FIELD_W-1:0]         first_i,
	input  logic [cpgd_pkg::FIELD_W-1:0]         first_j,
	input  logic [cpgd_pkg::FIELD_W-1:0]         first_k,
	input  logic [cpgd_pkg::FIELD_W-1:0]         second_i,
	input  logic [cpgd_pkg::FIELD_W-1:0]         second_j,
	input  logic [cpgd_pkg::FIELD_W-1:0]         second_k,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 within_res,
	output logic [cpgd_pkg::GAP_CELLS_W-1:0]     gap_cells,
	output logic [cpgd_pkg::GAP_LENGTH_W-1:0]    gap_length,
	input  logic                                 cfg_we,
	input  logic [cpgd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cpgd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int LEN_W = cpgd_pkg::CELL_LEN_W;
	localparam int CUT_W = cpgd_pkg::CUTOFF_W;
	localparam int SQ_W  = cpgd_pkg::CUTOFF_SQ_W;

	logic [LEN_W-1:0] cell_length_q;
	logic [CUT_W-1:0] cutoff_cells_q;
	logic             cutoff_enable_q;
	logic [SQ_W-1:0]  cutoff_sq_q;
	logic [LEN_W-1:0] len_data;

	logic                 f2s_valid, f2s_ready;
	cpgd_pkg::sum_word_t  f2s_word;
	logic                 s2b_valid, s2b_ready;
	cpgd_pkg::root_word_t s2b_word;

	assign len_data = cfg_data[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_length_q   <= cpgd_pkg::DEFAULT_CELL_LENGTH;
			cutoff_cells_q  <= '0;
			cutoff_enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cpgd_pkg::cfg_reg_t'(cfg_index))
				cpgd_pkg::REG_CELL_LENGTH: begin
					// zero length falls back to the default
					cell_length_q <= (len_data == '0) ? cpgd_pkg::DEFAULT_CELL_LENGTH
						: len_data;
				end
				cpgd_pkg::REG_CUTOFF_CELLS: begin
					cutoff_cells_q <= cfg_data[CUT_W-1:0];
				end
				cpgd_pkg::REG_CUTOFF_ENABLE: begin
					cutoff_enable_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// square the cutoff into its own register, off the cutoff register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_sq_q <= '0;
		end else begin
			cutoff_sq_q <= SQ_W'(cutoff_cells_q) * SQ_W'(cutoff_cells_q);
		end
	end

	cpgd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.first_i       (first_i),
		.first_j       (first_j),
		.first_k       (first_k),
		.second_i      (second_i),
		.second_j      (second_j),
		.second_k      (second_k),
		.cutoff_enable (cutoff_enable_q),
		.cutoff_sq     (cutoff_sq_q),
		.out_valid     (f2s_valid),
		.out_ready     (f2s_ready),
		.out_word      (f2s_word)
	);

	cpgd_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f2s_valid),
		.in_ready  (f2s_ready),
		.in_word   (f2s_word),
		.out_valid (s2b_valid),
		.out_ready (s2b_ready),
		.out_word  (s2b_word)
	);

	cpgd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s2b_valid),
		.in_ready    (s2b_ready),
		.in_word     (s2b_word),
		.cell_length (cell_length_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.within_res  (within_res),
		.gap_cells   (gap_cells),
		.gap_length  (gap_length)
	);

endmodule

FILE: hdl/cpgd_checker.sv
// Port-level checker for the cell pair gap filter, bound to the top level
`include "assert_macros.svh"

module cpgd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic                                 within_res,
	input logic [cpgd_pkg::GAP_CELLS_W-1:0]     gap_cells,
	input logic [cpgd_pkg::GAP_LENGTH_W-1:0]    gap_length
);

	// hold the result word while the sink stalls
	`CPGD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(gap_cells) && $stable(gap_length) && $stable(within_res), "result word changed under stall")

	// an empty output stage leaves room upstream
	`CPGD_ASSERT_IMPLY(a_ready_when_drained, !out_valid, in_ready, "input stalled with output stage empty")

	// touching cells scale to zero length
	`CPGD_ASSERT_IMPLY(a_zero_gap_length, out_valid && gap_cells == '0, gap_length == '0, "zero gap with nonzero length")

endmodule

bind cell_pair_gap_distance_filter cpgd_checker u_cpgd_checker (.*);

FILE: bench/cell_pair_gap_distance_filter_tb.sv
// Self-checking testbench for the cell pair gap distance filter: directed table, then random pairs
module cell_pair_gap_distance_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIELD_W      = cpgd_pkg::FIELD_W;
	localparam int INDEX_BITS   = cpgd_pkg::INDEX_BITS;
	localparam int FRAC_BITS    = cpgd_pkg::FRAC_BITS;
	localparam int CFG_IDX_W    = cpgd_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W   = cpgd_pkg::CFG_DATA_W;
	localparam int GAP_CELLS_W  = cpgd_pkg::GAP_CELLS_W;
	localparam int GAP_LENGTH_W = cpgd_pkg::GAP_LENGTH_W;
	localparam int CELL_LEN_W   = cpgd_pkg::CELL_LEN_W;
	localparam int CUTOFF_W     = cpgd_pkg::CUTOFF_W;
	localparam int CUT_SHIFT    = cpgd_pkg::CUT_SHIFT;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LATENCY       = 31;
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLDOFF_LEN   = 200;
	localparam int PHASES        = 8;
	localparam int PAIRS_PER_PHASE = 244;

	typedef struct {
		logic [FIELD_W-1:0] first_i, first_j, first_k;
		logic [FIELD_W-1:0] second_i, second_j, second_k;
	} cell_pair_t;

	typedef struct {
		logic                    in_range;
		logic [GAP_CELLS_W-1:0]  gap;
		logic [GAP_LENGTH_W-1:0] len;
	} gap_result_t;

	typedef struct {
		logic                  is_write;
		logic [CFG_IDX_W-1:0]  wr_index;
		logic [CFG_DATA_W-1:0] wr_data;
		cell_pair_t            pair;
		logic                  known;
		gap_result_t           want;
	} plan_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [FIELD_W-1:0]      first_i, first_j, first_k;
	logic [FIELD_W-1:0]      second_i, second_j, second_k;
	logic                    out_valid;
	logic                    out_ready;
	logic                    within_res;
	logic [GAP_CELLS_W-1:0]  gap_cells;
	logic [GAP_LENGTH_W-1:0] gap_length;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// register copy used by the predictor
	logic [CELL_LEN_W-1:0] cur_cell_length;
	logic [CUTOFF_W-1:0]   cur_cutoff;
	logic                  cur_cutoff_enable;

	gap_result_t expected_gaps[$];
	plan_row_t   plan[$];

	int errors;
	int pairs_sent;
	int results_checked;
	int within_seen;
	int settings_written;
	bit steady_in;
	bit steady_out;
	bit holdoff_request;
	bit holdoff_done;

	cell_pair_gap_distance_filter dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] axis_gap(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
		longint va, vb;
		va = longint'($signed(a[INDEX_BITS-1:0]));
		vb = longint'($signed(b[INDEX_BITS-1:0]));
		if (va == vb)
			return 64'd0;
		return (va < vb) ? 64'(vb - va - 1) : 64'(va - vb - 1);
	endfunction

	function automatic gap_result_t predict_gap(cell_pair_t p);
		logic [63:0] dx, dy, dz, sum, rad, root, trial, prod;
		int b;
		gap_result_t r;
		dx = axis_gap(p.first_i, p.second_i);
		dy = axis_gap(p.first_j, p.second_j);
		dz = axis_gap(p.first_k, p.second_k);
		sum = dx * dx + dy * dy + dz * dz;
		rad = sum << (2 * FRAC_BITS);
		// true root stays below 2^26, so starting at bit 31 keeps squares in 64 bits
		root = 64'd0;
		for (b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= rad)
				root = trial;
		end
		if (root > 64'(cpgd_pkg::GAP_CELLS_MAX))
			root = 64'(cpgd_pkg::GAP_CELLS_MAX);
		prod = (root * 64'(cur_cell_length)) >> FRAC_BITS;
		if (prod > 64'(cpgd_pkg::GAP_LENGTH_MAX))
			prod = 64'(cpgd_pkg::GAP_LENGTH_MAX);
		r.gap = root[GAP_CELLS_W-1:0];
		r.len = prod[GAP_LENGTH_W-1:0];
		if (cur_cutoff_enable)
			r.in_range = (sum << CUT_SHIFT) < (64'(cur_cutoff) * 64'(cur_cutoff));
		else
			r.in_range = 1'b1;
		return r;
	endfunction

	function automatic cell_pair_t make_pair(int fi, int fj, int fk, int si, int sj, int sk);
		cell_pair_t p;
		p.first_i  = 16'(fi);
		p.first_j  = 16'(fj);
		p.first_k  = 16'(fk);
		p.second_i = 16'(si);
		p.second_j = 16'(sj);
		p.second_k = 16'(sk);
		return p;
	endfunction

	function automatic plan_row_t pair_row(int fi, int fj, int fk, int si, int sj, int sk);
		plan_row_t r;
		r = '{default: '0};
		r.pair = make_pair(fi, fj, fk, si, sj, sk);
		return r;
	endfunction

	function automatic plan_row_t known_row(int fi, int fj, int fk, int si, int sj, int sk,
			bit w, longint g, longint l);
		plan_row_t r;
		r = pair_row(fi, fj, fk, si, sj, sk);
		r.known = 1'b1;
		r.want.in_range = w;
		r.want.gap = GAP_CELLS_W'(g);
		r.want.len = GAP_LENGTH_W'(l);
		return r;
	endfunction

	function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '{default: '0};
		r.is_write = 1'b1;
		r.wr_index = idx;
		r.wr_data = data;
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] corner_index();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic cell_pair_t random_pair();
		cell_pair_t p;
		int kind;
		int span;
		kind = $urandom_range(0, 99);
		p.first_i = 16'($urandom);
		p.first_j = 16'($urandom);
		p.first_k = 16'($urandom);
		if (kind < 10) begin
			p.first_i  = corner_index();
			p.first_j  = corner_index();
			p.first_k  = corner_index();
			p.second_i = corner_index();
			p.second_j = corner_index();
			p.second_k = corner_index();
		end else if (kind < 20) begin
			p.second_i = 16'($urandom);
			p.second_j = 16'($urandom);
			p.second_k = 16'($urandom);
		end else begin
			// neighbors near the cutoff, then a wider ring
			span = (kind < 80) ? 6 : 200;
			p.second_i = p.first_i + 16'($urandom_range(0, 2 * span) - span);
			p.second_j = p.first_j + 16'($urandom_range(0, 2 * span) - span);
			p.second_k = p.first_k + 16'($urandom_range(0, 2 * span) - span);
		end
		return p;
	endfunction

	task automatic send_pair(input cell_pair_t p, input logic known, input gap_result_t want);
		if (!steady_in && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 24);
		end
		in_valid <= 1'b1;
		first_i  <= p.first_i;
		first_j  <= p.first_j;
		first_k  <= p.first_k;
		second_i <= p.second_i;
		second_j <= p.second_j;
		second_k <= p.second_k;
		do
			@(posedge clk);
		while (!in_ready);
		expected_gaps.push_back(known ? want : predict_gap(p));
		pairs_sent++;
	endtask

	task automatic settle_pipeline();
		in_valid <= 1'b0;
		while (expected_gaps.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			cpgd_pkg::REG_CELL_LENGTH: begin
				cur_cell_length = (data[CELL_LEN_W-1:0] == '0) ?
					cpgd_pkg::DEFAULT_CELL_LENGTH : data[CELL_LEN_W-1:0];
			end
			cpgd_pkg::REG_CUTOFF_CELLS: cur_cutoff = data[CUTOFF_W-1:0];
			cpgd_pkg::REG_CUTOFF_ENABLE: cur_cutoff_enable = data[0];
			default: ;
		endcase
		settings_written++;
		@(posedge clk);
	endtask

	// receiver: random stalls, a quiet stretch, and one long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
				if (hold_left == 0)
					holdoff_done = 1'b1;
			end else if (holdoff_request) begin
				holdoff_request = 1'b0;
				hold_left = HOLDOFF_LEN;
				out_ready <= 1'b0;
			end else if (steady_out) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 24);
			end
		end
	end

	always @(posedge clk) begin
		gap_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_gaps.size() == 0) begin
				$error("result with no pair pending: within_res %0d gap_cells %0d gap_length %0d",
					within_res, gap_cells, gap_length);
				errors++;
			end else begin
				want = expected_gaps.pop_front();
				if (within_res !== want.in_range) begin
					$error("within_res: expected %0d, got %0d", want.in_range, within_res);
					errors++;
				end
				if (gap_cells !== want.gap) begin
					$error("gap_cells: expected %0d, got %0d", want.gap, gap_cells);
					errors++;
				end
				if (gap_length !== want.len) begin
					$error("gap_length: expected %0d, got %0d", want.len, gap_length);
					errors++;
				end
				if (want.in_range)
					within_seen++;
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		int quiet;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb: no progress for %0d cycles", QUIET_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		plan_row_t row;
		gap_result_t none;
		logic [CELL_LEN_W-1:0] cl;
		logic [CFG_DATA_W-1:0] cut;
		logic en;
		int ph;
		int n;

		none = '{default: '0};
		errors = 0;
		pairs_sent = 0;
		results_checked = 0;
		within_seen = 0;
		settings_written = 0;
		steady_in = 1'b0;
		steady_out = 1'b0;
		holdoff_request = 1'b0;
		holdoff_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		first_i = '0;
		first_j = '0;
		first_k = '0;
		second_i = '0;
		second_j = '0;
		second_k = '0;
		cfg_we = 1'b0;
		cfg_index = cpgd_pkg::REG_CELL_LENGTH;
		cfg_data = '0;
		cur_cell_length = cpgd_pkg::DEFAULT_CELL_LENGTH;
		cur_cutoff = '0;
		cur_cutoff_enable = 1'b0;

		// defaults after reset: 10.0 cell length, cutoff off
		plan.push_back(known_row(0, 0, 0, 0, 0, 0, 1, 0, 0));
		plan.push_back(known_row(0, 0, 0, 1, 0, 0, 1, 0, 0));
		plan.push_back(known_row(0, 0, 0, 0, 0, -2, 1, 256, 2560));
		plan.push_back(known_row(32767, 0, 0, -32768, 0, 0, 1, 16776704, 167767040));
		plan.push_back(pair_row(-32768, -32768, -32768, 32767, 32767, 32767));
		plan.push_back(known_row(0, 0, 0, 2, 2, 2, 1, 443, 4430));
		plan.push_back(pair_row(5, -7, 100, -3, 9, 97));
		plan.push_back(pair_row(-1, 0, 0, 1, 3, 0));
		// zero cell length falls back to the default; zero cutoff passes nothing
		plan.push_back(write_row(cpgd_pkg::REG_CELL_LENGTH, 24'h000000));
		plan.push_back(write_row(cpgd_pkg::REG_CUTOFF_ENABLE, 24'h000001));
		plan.push_back(known_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
		// cutoff of exactly one cell: a one-cell gap is not strictly below it
		plan.push_back(write_row(cpgd_pkg::REG_CUTOFF_CELLS, 24'h000100));
		plan.push_back(known_row(0, 0, 0, 0, 1, 0, 1, 0, 0));
		plan.push_back(known_row(0, 0, 0, 0, 2, 0, 0, 256, 2560));
		plan.push_back(write_row(cpgd_pkg::REG_CUTOFF_CELLS, 24'h000101));
		plan.push_back(known_row(0, 0, 0, 0, 2, 0, 1, 256, 2560));
		plan.push_back(write_row(cpgd_pkg::REG_CELL_LENGTH, 24'h00ffff));
		plan.push_back(write_row(cpgd_pkg::REG_CUTOFF_CELLS, 24'hffffff));
		plan.push_back(pair_row(-32768, -32768, -32768, 32767, 32767, 32767));
		plan.push_back(pair_row(32767, 0, 0, -32768, 0, 0));
		plan.push_back(known_row(0, 0, 0, 0, 0, 2, 1, 256, 65535));
		// unused index must change nothing; enable takes bit 0 only
		plan.push_back(write_row(cpgd_pkg::REG_CELL_LENGTH, 24'h000001));
		plan.push_back(write_row(REG_UNUSED, 24'h5a5a5a));
		plan.push_back(write_row(cpgd_pkg::REG_CUTOFF_ENABLE, 24'hfffffe));
		plan.push_back(known_row(0, 0, 0, 0, 0, 2, 1, 256, 1));
		plan.push_back(known_row(0, 0, 0, 0, 0, 3, 1, 512, 2));
		plan.push_back(pair_row(-32768, -32768, -32768, 32767, 32767, 32767));
		// upper data bits are dropped, so this is a zero write
		plan.push_back(write_row(cpgd_pkg::REG_CELL_LENGTH, 24'hab0000));
		plan.push_back(known_row(0, 0, 0, 2, 0, 0, 1, 256, 2560));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			row = plan[r];
			if (row.is_write) begin
				settle_pipeline();
				write_reg(row.wr_index, row.wr_data);
			end else begin
				send_pair(row.pair, row.known, row.want);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			settle_pipeline();
			case (ph)
				0: begin
					cl = 16'h0001;
					cut = 24'hffffff;
					en = 1'b1;
				end
				1: begin
					cl = 16'hffff;
					cut = 24'h000000;
					en = 1'b1;
				end
				2: begin
					cl = 16'($urandom_range(1, 65535));
					cut = 24'($urandom_range(0, 3072));
					en = 1'b1;
				end
				3: begin
					cl = 16'($urandom_range(1, 65535));
					cut = 24'($urandom);
					en = 1'b0;
				end
				default: begin
					cl = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
					cut = $urandom_range(0, 1) ? 24'($urandom_range(0, 3072)) : 24'($urandom);
					en = ($urandom_range(0, 3) != 0);
				end
			endcase
			write_reg(cpgd_pkg::REG_CELL_LENGTH, {8'($urandom), cl});
			write_reg(cpgd_pkg::REG_CUTOFF_CELLS, cut);
			write_reg(cpgd_pkg::REG_CUTOFF_ENABLE, {23'($urandom), en});
			steady_in = (ph == 3);
			steady_out = (ph == 3);
			if (ph == 5)
				holdoff_request = 1'b1;
			for (n = 0; n < PAIRS_PER_PHASE; n++)
				send_pair(random_pair(), 1'b0, none);
		end

		settle_pipeline();
		$display("tb: %0d cell pairs sent, %0d results checked, %0d of them within cutoff",
			pairs_sent, results_checked, within_seen);
		$display("tb: %0d register writes over %0d random settings, long output hold-off %s",
			settings_written, PHASES, holdoff_done ? "exercised" : "missed");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
